FILE: hdl/sorted_insert_table_top_defines.svh
// Assertion macros for the sorted insert table sequencer.
`ifndef SORTED_INSERT_TABLE_TOP_DEFINES_SVH
`define SORTED_INSERT_TABLE_TOP_DEFINES_SVH

`ifndef SYNTH
// Checked on every clock edge outside of reset.
`define SIT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define SIT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SIT_ASSERT(lbl, prop, msg)
`define SIT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hdl/sit_pkg.sv
// Shared types and codes for the sorted insert table.
package sit_pkg;

    // Request kinds on the input channel.
    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_READ   = 1'b1
    } t_req_type;

    // Status codes reported with every result.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_CMP,
        S_PLACE,
        S_RDATA,
        S_DONE
    } t_state;

    // Result handoff from the sequencer to the output stage.
    typedef struct packed {
        logic    done;
        t_status status;
    } t_seq_res;

endpackage

FILE: hdl/sorted_insert_table_top.sv
// Top level of the sorted insert table: sequencer, entry memory and output register.
//
// Keeps up to DEPTH signed values in ascending order. Input beats carry a
// request: insert i_value in order, or read the entry at 1-based rank
// i_position (rank 0 reads rank 1). Every input beat gives exactly one
// output beat with the read value, a status and the entry count after it.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low.
// One request is worked on at a time, and o_in_stall is high meanwhile.
// A read passes through fetch and read-data states before its result is ready; a dropped
// insert or a failed read goes straight to the result. An insert fetches and compares
// each larger entry in turn and moves it up, and ends in a place state when it lands at
// the bottom of the table: each move is one read and one write of the entry memory
// through the shared comparator. The next request is accepted in the cycle after the
// previous result enters the output register.
// The output register frees the sequencer, so the next request is accepted
// while a result still waits; a stalled result holds its fields.
// Reset clears the entry count and the control state; the entry memory
// needs no clearing pass, since only entries below the count are read.
module sorted_insert_table_top #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_req_type,
    input  logic signed [VALUE_WIDTH-1:0]  i_value,
    input  logic [$clog2(DEPTH+1)-1:0]     i_position,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [VALUE_WIDTH-1:0]  o_read_value,
    output logic [1:0]                     o_status,
    output logic [$clog2(DEPTH+1)-1:0]     o_entry_count
);
    import sit_pkg::*;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    t_seq_res                      seq_res;
    logic                          seq_busy;
    logic                          take;
    logic signed [VALUE_WIDTH-1:0] res_value;
    logic [CNT_W-1:0]              res_count;
    logic                          wr_en;
    logic [ADDR_W-1:0]             wr_addr;
    logic signed [VALUE_WIDTH-1:0] wr_data;
    logic [ADDR_W-1:0]             rd_addr;
    logic signed [VALUE_WIDTH-1:0] rd_data;

    logic                          r_out_valid;
    logic signed [VALUE_WIDTH-1:0] r_out_value;
    t_status                       r_out_status;
    logic [CNT_W-1:0]              r_out_count;

    sit_seq #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .i_value     (i_value),
        .i_position  (i_position),
        .o_busy      (seq_busy),
        .i_take      (take),
        .o_res       (seq_res),
        .o_res_value (res_value),
        .o_res_count (res_count),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    sit_store #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // A finished result moves into the output register once it is free.
    assign take = seq_res.done && (!r_out_valid || !i_out_stall);

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_value  <= res_value;
            r_out_status <= seq_res.status;
            r_out_count  <= res_count;
        end
    end

    assign o_in_stall    = seq_busy;
    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_out_value;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;

endmodule

FILE: hdl/sit_store.sv
// Entry memory of the sorted insert table: one write port, one registered read port.
module sit_store #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]       i_wr_addr,
    input  logic signed [VALUE_WIDTH-1:0]  i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]       i_rd_addr,
    output logic signed [VALUE_WIDTH-1:0]  o_rd_data
);

    logic signed [VALUE_WIDTH-1:0] r_mem [DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/sit_seq.sv
// Sequencer of the sorted insert table: request decode, shift loop and shared comparator.
`include "sorted_insert_table_top_defines.svh"

module sit_seq #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_req_type,
    input  logic signed [VALUE_WIDTH-1:0]     i_value,
    input  logic [$clog2(DEPTH+1)-1:0]        i_position,
    output logic                              o_busy,
    input  logic                              i_take,
    output sit_pkg::t_seq_res                 o_res,
    output logic signed [VALUE_WIDTH-1:0]     o_res_value,
    output logic [$clog2(DEPTH+1)-1:0]        o_res_count,
    output logic                              o_wr_en,
    output logic [$clog2(DEPTH)-1:0]          o_wr_addr,
    output logic signed [VALUE_WIDTH-1:0]     o_wr_data,
    output logic [$clog2(DEPTH)-1:0]          o_rd_addr,
    input  logic signed [VALUE_WIDTH-1:0]     i_rd_data
);
    import sit_pkg::*;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    t_state                        r_state, n_state;
    logic                          r_is_read, n_is_read;
    logic signed [VALUE_WIDTH-1:0] r_val, n_val;
    logic [CNT_W-1:0]              r_idx, n_idx;
    logic [CNT_W-1:0]              r_count, n_count;
    logic signed [VALUE_WIDTH-1:0] r_res_val, n_res_val;
    t_status                       r_res_st, n_res_st;
    logic [CNT_W-1:0]              rank;
    logic [CNT_W-1:0]              idx_m1;
    logic                          entry_less;

    // Rank zero reads the smallest entry, like rank one.
    assign rank = (i_position == '0) ? CNT_W'(1) : i_position;
    assign idx_m1 = r_idx - CNT_W'(1);

    // Shared comparator: stored entry strictly below the value being inserted.
    assign entry_less = (i_rd_data < r_val);

    // State register and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_is_read <= n_is_read;
        r_val     <= n_val;
        r_idx     <= n_idx;
        r_res_val <= n_res_val;
        r_res_st  <= n_res_st;
    end

    // Next state, memory control and result.
    always_comb begin
        n_state   = r_state;
        n_is_read = r_is_read;
        n_val     = r_val;
        n_idx     = r_idx;
        n_count   = r_count;
        n_res_val = r_res_val;
        n_res_st  = r_res_st;
        o_wr_en   = 1'b0;
        o_wr_addr = r_idx[ADDR_W-1:0];
        o_wr_data = r_val;
        o_rd_addr = idx_m1[ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_is_read = (i_req_type == REQ_READ);
                    n_val     = i_value;
                    n_res_val = '0;
                    n_res_st  = ST_OK;
                    if (i_req_type == REQ_READ) begin
                        if (rank > r_count) begin
                            // Rank beyond the stored entries, empty table included.
                            n_res_val = '1;
                            n_res_st  = ST_RANGE;
                            n_state   = S_DONE;
                        end else begin
                            n_idx   = rank;
                            n_state = S_FETCH;
                        end
                    end else if (r_count == CNT_W'(DEPTH)) begin
                        // Full table: the insert is dropped.
                        n_res_st = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        // Start the scan at the top of the occupied range.
                        n_idx   = r_count;
                        n_state = (r_count == '0) ? S_PLACE : S_FETCH;
                    end
                end
            end

            S_FETCH: begin
                n_state = r_is_read ? S_RDATA : S_CMP;
            end

            S_CMP: begin
                if (entry_less) begin
                    // Slot found above a smaller entry.
                    o_wr_en = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    n_state = S_DONE;
                end else begin
                    // Move the larger entry up one place.
                    o_wr_en   = 1'b1;
                    o_wr_data = i_rd_data;
                    n_idx     = idx_m1;
                    n_state   = (idx_m1 == '0) ? S_PLACE : S_FETCH;
                end
            end

            S_PLACE: begin
                o_wr_en = 1'b1;
                n_count = r_count + CNT_W'(1);
                n_state = S_DONE;
            end

            S_RDATA: begin
                n_res_val = i_rd_data;
                n_state   = S_DONE;
            end

            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res       = '{done: (r_state == S_DONE), status: r_res_st};
    assign o_res_value = r_res_val;
    assign o_res_count = r_count;

    // The count never exceeds the table depth.
    `SIT_ASSERT(a_count_bound, r_count <= CNT_W'(DEPTH), "stored count above depth")
    // The count only ever grows by one, and only when an insert completes.
    `SIT_ASSERT(a_count_step,
        (r_count != $past(r_count)) |->
        (r_count == $past(r_count) + CNT_W'(1) && r_state == S_DONE),
        "stored count moved by other than one insert")
    // A fetch always addresses an occupied entry.
    `SIT_ASSERT(a_fetch_range, (r_state == S_FETCH) |-> (r_idx != '0 && r_idx <= r_count), "fetch outside occupied range")
    // Writes stay inside the table.
    `SIT_ASSERT(a_write_range, o_wr_en |-> (r_idx < CNT_W'(DEPTH) && r_idx <= r_count), "write outside table")

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the sorted insert table: a directed table of beats, then random beats.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sit_pkg::*;

    localparam int DEPTH         = 16;
    localparam int VW            = 32;
    localparam int PW            = $clog2(DEPTH + 1);
    localparam int RANDOM_ITEMS  = 1500;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 10000;
    localparam int DIR_ROWS      = 27;

    // One result beat as the block reports it.
    typedef struct packed {
        logic signed [VW-1:0] value;
        t_status              status;
        logic [PW-1:0]        count;
    } t_result;

    // One row of the directed table; typed rows carry their own expected result.
    typedef struct packed {
        t_req_type            req;
        logic signed [VW-1:0] value;
        logic [PW-1:0]        position;
        bit                   typed;
        t_result              want;
    } t_directed_row;

    typedef enum int {
        STALL_NONE,
        STALL_SOME,
        STALL_MOST
    } t_stall_mode;

    localparam t_result NO_WANT = '{32'sd0, ST_OK, 5'd0};
    localparam logic signed [VW-1:0] VAL_MIN = 32'sh80000000;
    localparam logic signed [VW-1:0] VAL_MAX = 32'sh7FFFFFFF;
    localparam logic signed [VW-1:0] FILLER  = 32'sh5A5A5A5A;

    logic                 i_clk;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_stall;
    logic                 i_req_type   = 1'b0;
    logic signed [VW-1:0] i_value      = '0;
    logic [PW-1:0]        i_position   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall  = 1'b0;
    logic signed [VW-1:0] o_read_value;
    logic [1:0]           o_status;
    logic [PW-1:0]        o_entry_count;

    // Shadow copy of the sorted table and its fill level.
    logic signed [VW-1:0] shadow_entries [DEPTH];
    int unsigned          shadow_count = 0;

    t_result expected_results [$];
    int      mismatch_count = 0;
    bit      hold_off_req   = 1'b0;
    bit      hold_off_done  = 1'b0;

    // Empty-table reads, extremes and duplicates first; then fill up, overflow and read back.
    t_directed_row dir_rows [DIR_ROWS] = '{
        '{REQ_READ,   FILLER,        5'd0,  1'b1, '{-32'sd1, ST_RANGE, 5'd0}},
        '{REQ_READ,   FILLER,        5'd31, 1'b1, '{-32'sd1, ST_RANGE, 5'd0}},
        '{REQ_INSERT, 32'sd0,        5'd31, 1'b1, '{32'sd0,  ST_OK,    5'd1}},
        '{REQ_INSERT, VAL_MAX,       5'd0,  1'b1, '{32'sd0,  ST_OK,    5'd2}},
        '{REQ_INSERT, VAL_MIN,       5'd0,  1'b1, '{32'sd0,  ST_OK,    5'd3}},
        '{REQ_INSERT, -32'sd1,       5'd0,  1'b1, '{32'sd0,  ST_OK,    5'd4}},
        '{REQ_INSERT, 32'sd0,        5'd0,  1'b1, '{32'sd0,  ST_OK,    5'd5}},
        '{REQ_READ,   FILLER,        5'd0,  1'b1, '{VAL_MIN, ST_OK,    5'd5}},
        '{REQ_READ,   FILLER,        5'd2,  1'b0, NO_WANT},
        '{REQ_READ,   FILLER,        5'd5,  1'b1, '{VAL_MAX, ST_OK,    5'd5}},
        '{REQ_READ,   FILLER,        5'd6,  1'b1, '{-32'sd1, ST_RANGE, 5'd5}},
        '{REQ_READ,   FILLER,        5'd17, 1'b1, '{-32'sd1, ST_RANGE, 5'd5}},
        '{REQ_INSERT, 32'sd5,        5'd0,  1'b1, '{32'sd0,  ST_OK,    5'd6}},
        '{REQ_INSERT, 32'sd3,        5'd0,  1'b1, '{32'sd0,  ST_OK,    5'd7}},
        '{REQ_INSERT, 32'sd3,        5'd0,  1'b1, '{32'sd0,  ST_OK,    5'd8}},
        '{REQ_INSERT, -32'sd7,       5'd0,  1'b1, '{32'sd0,  ST_OK,    5'd9}},
        '{REQ_INSERT, 32'sd100,      5'd0,  1'b1, '{32'sd0,  ST_OK,    5'd10}},
        '{REQ_INSERT, 32'sh7FFFFFFE, 5'd0,  1'b1, '{32'sd0,  ST_OK,    5'd11}},
        '{REQ_INSERT, 32'sd1,        5'd0,  1'b1, '{32'sd0,  ST_OK,    5'd12}},
        '{REQ_INSERT, 32'sh80000001, 5'd0,  1'b1, '{32'sd0,  ST_OK,    5'd13}},
        '{REQ_INSERT, 32'sd42,       5'd0,  1'b1, '{32'sd0,  ST_OK,    5'd14}},
        '{REQ_INSERT, 32'sd9,        5'd0,  1'b1, '{32'sd0,  ST_OK,    5'd15}},
        '{REQ_INSERT, VAL_MIN,       5'd0,  1'b1, '{32'sd0,  ST_OK,    5'd16}},
        '{REQ_INSERT, 32'sd77,       5'd0,  1'b1, '{32'sd0,  ST_FULL,  5'd16}},
        '{REQ_READ,   FILLER,        5'd16, 1'b1, '{VAL_MAX, ST_OK,    5'd16}},
        '{REQ_READ,   FILLER,        5'd9,  1'b0, NO_WANT},
        '{REQ_READ,   FILLER,        5'd31, 1'b1, '{-32'sd1, ST_RANGE, 5'd16}}
    };

    sorted_insert_table_top #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VW)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Applies one request to the shadow table and returns the result it should give.
    function automatic void predict_result(input t_req_type req, input logic signed [VW-1:0] val,
                                           input logic [PW-1:0] pos, output t_result res);
        int unsigned slot;
        int unsigned rank;
        res = NO_WANT;
        if (req == REQ_INSERT) begin
            if (shadow_count >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // The new value goes after every strictly smaller entry.
                slot = 0;
                while (slot < shadow_count && shadow_entries[slot] < val) slot++;
                for (int unsigned i = shadow_count; i > slot; i--) begin
                    shadow_entries[i] = shadow_entries[i - 1];
                end
                shadow_entries[slot] = val;
                shadow_count++;
            end
        end else begin
            rank = (pos == 0) ? 1 : pos;
            if (rank > shadow_count) begin
                res.status = ST_RANGE;
                res.value  = -1;
            end else begin
                res.value = shadow_entries[rank - 1];
            end
        end
        res.count = shadow_count[PW-1:0];
    endfunction

    // Offers one beat and holds it until accepted, then records what it should produce.
    task automatic offer_request(input t_req_type req, input logic signed [VW-1:0] val,
                                 input logic [PW-1:0] pos, input bit typed,
                                 input t_result typed_want);
        t_result predicted;
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_value    <= val;
        i_position <= pos;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_result(req, val, pos, predicted);
        expected_results.push_back(typed ? typed_want : predicted);
    endtask

    // Bursts of back-to-back beats separated by short random gaps.
    task automatic pace_sender(inout int burst_left);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    // Stimulus: reset, directed table, random beats, then drain and verdict.
    initial begin : stimulus
        int                   burst_left;
        int                   drain;
        t_req_type            req;
        logic signed [VW-1:0] val;
        logic [PW-1:0]        pos;
        burst_left = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < DIR_ROWS; n++) begin
            pace_sender(burst_left);
            offer_request(dir_rows[n].req, dir_rows[n].value, dir_rows[n].position,
                          dir_rows[n].typed, dir_rows[n].want);
        end

        // The table is full from here on: reads at every rank, inserts are dropped.
        hold_off_req = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            req = ($urandom_range(0, 3) == 0) ? REQ_INSERT : REQ_READ;
            val = $urandom();
            pos = ($urandom_range(0, 3) == 0) ? PW'($urandom_range(0, 31))
                                              : PW'($urandom_range(0, 17));
            pace_sender(burst_left);
            offer_request(req, val, pos, 1'b0, NO_WANT);
        end
        i_in_valid <= 1'b0;

        drain = 0;
        while (expected_results.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d result beats never arrived", expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // Output stall: changing stall patterns, with one long hold-off to back the block up once the table is full.
    initial begin : receiver
        t_stall_mode mode;
        int          mode_left;
        mode      = STALL_NONE;
        mode_left = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_off_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_done = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                case (mode)
                    STALL_NONE: i_out_stall <= 1'b0;
                    STALL_SOME: i_out_stall <= 1'($urandom_range(0, 1));
                    default:    i_out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result beat with no request pending");
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_read_value !== want.value) begin
                    $error("read_value: expected %0d, got %0d", want.value, o_read_value);
                    mismatch_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatch_count++;
                end
                if (o_entry_count !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count, o_entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Hard stop in case the handshake hangs.
    initial begin : watchdog
        #10_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
